@@ src/msr_pkg.sv @@
// ----------------------------------------------------------------------------
// msr_pkg
// Types and constants shared by the multi-channel servo ramp block.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int ANGLE_W = 16;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int IDXF_W  = 4;
    localparam int PROD_W  = 32;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic [IDXF_W-1:0]          servo_index;
        logic signed [ANGLE_W-1:0]  target_angle;
        logic [DUR_W-1:0]           move_duration_ms;
        logic [TIME_W-1:0]          now_ms;
    } t_cmd;

    typedef struct packed {
        logic [IDXF_W-1:0]          out_servo_index;
        logic signed [ANGLE_W-1:0]  out_angle;
        logic                       move_finished;
        logic                       last_of_run;
    } t_result;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]  start_angle;
        logic signed [ANGLE_W-1:0]  goal_angle;
        logic [TIME_W-1:0]          start_time;
        logic [DUR_W-1:0]           duration;
    } t_move;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_SCAN,
        S_LOAD,
        S_MUL,
        S_DIV
    } t_state;

endpackage

@@ src/msr_ram.sv @@
// ----------------------------------------------------------------------------
// msr_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module msr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/msr_div.sv @@
// ----------------------------------------------------------------------------
// msr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msr_div
    import msr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DUR_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DUR_W-1:0]  r_rem;
    logic [DUR_W-1:0]  r_div;
    logic [PROD_W-1:0] r_quo;

    logic [DUR_W:0]    rem_sh;
    logic              ge;
    logic [DUR_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[PROD_W-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/multi_servo_linear_ramp.sv @@
// ----------------------------------------------------------------------------
// multi_servo_linear_ramp
// Linear angle ramps for up to NUM_SERVOS servo channels.
// Set-target: busy for the set state only; a result (only for a zero duration)
//   is registered out after it, and a new transaction can then be accepted.
// Tick: channels swept in index order; an idle channel is only scanned, a
//   finished one scanned and loaded, an interpolating one scanned, loaded,
//   multiplied and divided (serial divider); each result follows its channel
//   in the next cycle. No backpressure on results. Synchronous reset: all
//   channels inactive, angles read as zero, command acceptance enabled.
// ----------------------------------------------------------------------------
module multi_servo_linear_ramp
    import msr_pkg::*;
#(
    parameter int NUM_SERVOS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata
);

    localparam int IDX_W  = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int MOVE_W = $bits(t_move);

    t_state r_state, n_state;

    logic                      r_enable;
    logic [NUM_SERVOS-1:0]     r_active;
    logic [NUM_SERVOS-1:0]     r_cur_vld;
    logic [IDX_W-1:0]          r_ptr;
    logic [TIME_W-1:0]         r_now;
    logic signed [ANGLE_W-1:0] r_target;
    logic [DUR_W-1:0]          r_dur;
    logic signed [ANGLE_W-1:0] r_base;
    logic                      r_neg;
    logic [DUR_W-1:0]          r_mag;
    logic [DUR_W-1:0]          r_elapsed;
    logic                      r_strobe;
    t_result                   r_result;

    logic                      cur_we;
    logic [ANGLE_W-1:0]        cur_wdata;
    logic [IDX_W-1:0]          cur_raddr;
    logic [ANGLE_W-1:0]        cur_rdata;
    logic                      mv_we;
    t_move                     mv_wr;
    logic [MOVE_W-1:0]         mv_rdata;
    t_move                     mv_rd;

    logic                      div_start;
    logic                      div_done;
    logic [PROD_W-1:0]         div_quo;
    logic [PROD_W-1:0]         product;

    logic                      accept;
    logic                      in_range;
    logic                      at_end;
    logic                      ptr_act;
    logic                      last;
    logic [TIME_W-1:0]         elapsed;
    logic                      fin;
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]          diff_mag;
    logic signed [ANGLE_W-1:0] cur_val;
    logic [ANGLE_W-1:0]        q16;
    logic signed [ANGLE_W-1:0] interp;

    logic                      emit;
    t_result                   emit_res;
    logic                      set_act;
    logic                      clr_act;
    logic                      step;

    msr_ram #(.WIDTH(ANGLE_W), .DEPTH(NUM_SERVOS)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (r_ptr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    msr_ram #(.WIDTH(MOVE_W), .DEPTH(NUM_SERVOS)) u_move_ram (
        .i_clk   (i_clk),
        .i_we    (mv_we),
        .i_waddr (r_ptr),
        .i_wdata (mv_wr),
        .i_raddr (r_ptr),
        .o_rdata (mv_rdata)
    );

    assign product = PROD_W'(r_mag) * PROD_W'(r_elapsed);

    msr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_dur),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        accept    = i_start && (r_state == S_IDLE) && r_enable;
        in_range  = 32'(i_cmd.servo_index) < NUM_SERVOS;
        cur_raddr = i_cmd.servo_index[IDX_W-1:0];
        at_end    = (r_ptr == IDX_W'(NUM_SERVOS - 1));
        ptr_act   = r_active[r_ptr];
        mv_rd     = t_move'(mv_rdata);
        elapsed   = r_now - mv_rd.start_time;
        fin       = (elapsed >= TIME_W'(mv_rd.duration));
        diff      = (ANGLE_W+1)'(mv_rd.goal_angle) - (ANGLE_W+1)'(mv_rd.start_angle);
        diff_mag  = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : diff;
        cur_val   = r_cur_vld[r_ptr] ? cur_rdata : '0;
        q16       = div_quo[ANGLE_W-1:0];
        interp    = r_neg ? (r_base - q16) : (r_base + q16);
        last      = 1'b1;
        for (int j = 0; j < NUM_SERVOS; j++) begin
            if (j > 32'(r_ptr) && r_active[j]) begin
                last = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == OP_SET) begin
                        n_state = in_range ? S_SET : S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SET: n_state = S_IDLE;
            S_SCAN: begin
                if (ptr_act) begin
                    n_state = S_LOAD;
                end else if (at_end) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                if (fin) begin
                    n_state = at_end ? S_IDLE : S_SCAN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = at_end ? S_IDLE : S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cur_we    = 1'b0;
        cur_wdata = '0;
        mv_we     = 1'b0;
        mv_wr     = '0;
        div_start = 1'b0;
        emit      = 1'b0;
        emit_res  = '0;
        set_act   = 1'b0;
        clr_act   = 1'b0;
        step      = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_SET: begin
                if (r_dur == '0) begin
                    cur_we    = 1'b1;
                    cur_wdata = r_target;
                    clr_act   = 1'b1;
                    emit      = 1'b1;
                    emit_res  = '{IDXF_W'(r_ptr), r_target, 1'b1, 1'b1};
                end else begin
                    mv_we   = 1'b1;
                    mv_wr   = '{cur_val, r_target, r_now, r_dur};
                    set_act = 1'b1;
                end
            end
            S_SCAN: step = !ptr_act;
            S_LOAD: begin
                if (fin) begin
                    cur_we    = 1'b1;
                    cur_wdata = mv_rd.goal_angle;
                    clr_act   = 1'b1;
                    emit      = 1'b1;
                    emit_res  = '{IDXF_W'(r_ptr), mv_rd.goal_angle, 1'b1, last};
                    step      = 1'b1;
                end
            end
            S_MUL: div_start = 1'b1;
            S_DIV: begin
                if (div_done) begin
                    cur_we    = 1'b1;
                    cur_wdata = interp;
                    emit      = 1'b1;
                    emit_res  = '{IDXF_W'(r_ptr), interp, 1'b0, last};
                    step      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enable  <= 1'b1;
            r_active  <= '0;
            r_cur_vld <= '0;
            r_strobe  <= 1'b0;
            r_ptr     <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (set_act) begin
                r_active[r_ptr] <= 1'b1;
            end
            if (clr_act) begin
                r_active[r_ptr] <= 1'b0;
            end
            if (cur_we) begin
                r_cur_vld[r_ptr] <= 1'b1;
            end
            if (accept) begin
                r_ptr <= (i_cmd.opcode == OP_SET) ? cur_raddr : '0;
            end else if (step && !at_end) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now    <= i_cmd.now_ms;
            r_target <= i_cmd.target_angle;
            r_dur    <= i_cmd.move_duration_ms;
        end
        if (r_state == S_LOAD) begin
            r_base    <= mv_rd.start_angle;
            r_neg     <= diff[ANGLE_W];
            r_mag     <= diff_mag[DUR_W-1:0];
            r_elapsed <= elapsed[DUR_W-1:0];
            r_dur     <= mv_rd.duration;
        end
        if (emit) begin
            r_result <= emit_res;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
